// ===== hw/rtl/wavp_pkg.sv =====
// shared types, codes and constants of the wav pcm16 stream parser
package wavp_pkg;

	// frame counter width, also the width of max_frames and frames_out
	localparam int FC_W = 24;
	// width of the announced frame count
	localparam int HDR_W = 31;
	// result queue depth
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// chunk tags as they build up little endian in the gather word
	localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
	localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
	localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
	localparam logic [31:0] TAG_DATA = 32'h6174_6164;

	// fmt chunk fields
	localparam logic [31:0] FMT_MIN_SIZE  = 32'd16;
	localparam logic [15:0] FMT_PCM       = 16'd1;
	localparam logic [15:0] CH_MONO       = 16'd1;
	localparam logic [15:0] CH_STEREO     = 16'd2;
	localparam logic [15:0] BITS_16       = 16'd16;
	localparam logic [3:0]  FPOS_FORMAT   = 4'd1;
	localparam logic [3:0]  FPOS_CHANNELS = 4'd3;
	localparam logic [3:0]  FPOS_RATE     = 4'd7;
	localparam logic [3:0]  FPOS_BITS     = 4'd15;

	// configuration register indexes
	localparam logic [0:0] CFG_EXPECTED_RATE = 1'b0;
	localparam logic [0:0] CFG_MAX_FRAMES    = 1'b1;

	// result kinds
	localparam logic KIND_FRAME   = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	// summary status codes
	typedef enum logic [3:0] {
		ST_OK        = 4'd0,
		ST_BAD_TAG   = 4'd1,
		ST_FMT_SHORT = 4'd2,
		ST_TRUNC     = 4'd3,
		ST_NOT_PCM   = 4'd4,
		ST_BAD_CH    = 4'd5,
		ST_NOT_16    = 4'd6,
		ST_BAD_RATE  = 4'd7,
		ST_NO_FRAMES = 4'd8
	} status_t;

	// one result item
	typedef struct packed {
		logic               kind;
		logic signed [15:0] left_sample;
		logic signed [15:0] right_sample;
		logic [3:0]         status;
		logic [31:0]        sample_rate;
		logic [1:0]         channel_count;
		logic [HDR_W-1:0]   header_frames;
		logic [FC_W-1:0]    frames_out;
		logic               last_result;
	} result_t;

	// up to two results pushed by one byte, frame first
	typedef struct packed {
		logic [1:0] count;
		result_t    r0;
		result_t    r1;
	} res_push_t;

endpackage

// ===== hw/rtl/wavp_parser.sv =====
// byte input register, header walk, frame assembly and summary generation
module wavp_parser
	import wavp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        byte_in,
	input  logic              last_byte,
	input  logic [31:0]       expected_rate,
	input  logic [FC_W-1:0]   max_frames,
	input  logic              room,
	output res_push_t         push
);

	typedef enum logic [8:0] {
		PH_RIFF  = 9'b000000001,
		PH_RSIZE = 9'b000000010,
		PH_WAVE  = 9'b000000100,
		PH_CID   = 9'b000001000,
		PH_CSIZE = 9'b000010000,
		PH_FMT   = 9'b000100000,
		PH_SKIP  = 9'b001000000,
		PH_DATA  = 9'b010000000,
		PH_DONE  = 9'b100000000
	} phase_t;

	typedef enum logic [1:0] {
		CK_OTHER = 2'd0,
		CK_FMT   = 2'd1,
		CK_DATA  = 2'd2
	} chunk_t;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       advance;

	// file state
	phase_t            phase_q, phase_d;
	logic [1:0]        byte_index_q, byte_index_d;
	logic [31:0]       gather_q, gather_d;
	logic [31:0]       skip_q, skip_d;
	logic              pad_q, pad_d;
	logic              have_fmt_q, have_fmt_d;
	logic [15:0]       format_q, format_d;
	logic [15:0]       channels_q, channels_d;
	logic [31:0]       rate_q, rate_d;
	logic [15:0]       bits_q, bits_d;
	logic [FC_W-1:0]   target_q, target_d;
	logic [FC_W-1:0]   count_q, count_d;
	logic [15:0]       held_left_q, held_left_d;
	logic [3:0]        fmt_pos_q, fmt_pos_d;
	chunk_t            chunk_q, chunk_d;
	logic [HDR_W-1:0]  hdr_q, hdr_d;

	// per byte results
	logic [31:0]       gword;
	logic              full;
	logic              frame_req;
	logic [15:0]       frame_l;
	logic [15:0]       frame_r;
	logic              sum_req;
	status_t           sum_status;
	logic [FC_W-1:0]   tgt;
	result_t           frame_res;
	result_t           sum_res;

	assign advance  = valid_s1 && room;
	assign in_stall = valid_s1 && !room;

	// input register: refilled whenever the held byte moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= byte_in;
			last_s1 <= last_byte;
		end
	end

	// next state and results for the held byte
	always_comb begin
		phase_d     = phase_q;
		byte_index_d = byte_index_q;
		gather_d    = gather_q;
		skip_d      = skip_q;
		pad_d       = pad_q;
		have_fmt_d  = have_fmt_q;
		format_d    = format_q;
		channels_d  = channels_q;
		rate_d      = rate_q;
		bits_d      = bits_q;
		target_d    = target_q;
		count_d     = count_q;
		held_left_d = held_left_q;
		fmt_pos_d   = fmt_pos_q;
		chunk_d     = chunk_q;
		hdr_d       = hdr_q;
		frame_req   = 1'b0;
		frame_l     = '0;
		frame_r     = '0;
		sum_req     = 1'b0;
		sum_status  = ST_OK;
		tgt         = '0;
		gword       = {byte_s1, gather_q[31:8]};
		full        = 1'b0;

		// header words gather four bytes at a time
		if (phase_q inside {PH_RIFF, PH_RSIZE, PH_WAVE, PH_CID, PH_CSIZE}) begin
			gather_d     = gword;
			full         = (byte_index_q == 2'd3);
			byte_index_d = byte_index_q + 2'd1;
		end

		unique case (phase_q)
			PH_RIFF: begin
				if (full) begin
					if (gword != TAG_RIFF) begin
						sum_req    = 1'b1;
						sum_status = ST_BAD_TAG;
					end else begin
						phase_d = PH_RSIZE;
					end
				end
			end
			PH_RSIZE: begin
				if (full) phase_d = PH_WAVE;
			end
			PH_WAVE: begin
				if (full) begin
					if (gword != TAG_WAVE) begin
						sum_req    = 1'b1;
						sum_status = ST_BAD_TAG;
					end else begin
						phase_d = PH_CID;
					end
				end
			end
			PH_CID: begin
				if (full) begin
					if (gword == TAG_FMT) chunk_d = CK_FMT;
					else if (gword == TAG_DATA) chunk_d = CK_DATA;
					else chunk_d = CK_OTHER;
					phase_d = PH_CSIZE;
				end
			end
			PH_CSIZE: begin
				if (full) begin
					case (chunk_q)
						CK_FMT: begin
							if (gword < FMT_MIN_SIZE) begin
								sum_req    = 1'b1;
								sum_status = ST_FMT_SHORT;
							end else begin
								skip_d    = gword - FMT_MIN_SIZE;
								fmt_pos_d = '0;
								phase_d   = PH_FMT;
							end
						end
						CK_DATA: begin
							// header checks in priority order
							if (!have_fmt_q) begin
								sum_req    = 1'b1;
								sum_status = ST_TRUNC;
							end else if (format_q != FMT_PCM) begin
								sum_req    = 1'b1;
								sum_status = ST_NOT_PCM;
							end else if (channels_q != CH_MONO && channels_q != CH_STEREO) begin
								sum_req    = 1'b1;
								sum_status = ST_BAD_CH;
							end else if (bits_q != BITS_16) begin
								sum_req    = 1'b1;
								sum_status = ST_NOT_16;
							end else if (expected_rate != '0 && rate_q != expected_rate) begin
								sum_req    = 1'b1;
								sum_status = ST_BAD_RATE;
							end else begin
								// two bytes per sample, one or two samples per frame
								if (channels_q == CH_STEREO) hdr_d = {1'b0, gword[31:2]};
								else hdr_d = gword[31:1];
								if (hdr_d > {{(HDR_W-FC_W){1'b0}}, max_frames}) tgt = max_frames;
								else tgt = hdr_d[FC_W-1:0];
								target_d     = tgt;
								count_d      = '0;
								byte_index_d = '0;
								if (tgt == '0) begin
									sum_req    = 1'b1;
									sum_status = ST_NO_FRAMES;
								end else begin
									phase_d = PH_DATA;
								end
							end
						end
						default: begin
							skip_d  = gword;
							pad_d   = gword[0];
							phase_d = (gword == '0) ? PH_CID : PH_SKIP;
						end
					endcase
				end
			end
			PH_FMT: begin
				gather_d = gword;
				case (fmt_pos_q)
					FPOS_FORMAT:   format_d   = gword[31:16];
					FPOS_CHANNELS: channels_d = gword[31:16];
					FPOS_RATE:     rate_d     = gword;
					FPOS_BITS:     bits_d     = gword[31:16];
					default: ;
				endcase
				if (fmt_pos_q == FPOS_BITS) begin
					have_fmt_d   = 1'b1;
					byte_index_d = '0;
					pad_d        = 1'b0;
					phase_d      = (skip_q == '0) ? PH_CID : PH_SKIP;
				end else begin
					fmt_pos_d = fmt_pos_q + 4'd1;
				end
			end
			PH_SKIP: begin
				if (skip_q != '0) skip_d = skip_q - 32'd1;
				else pad_d = 1'b0;
				if (skip_d == '0 && !pad_d) begin
					phase_d      = PH_CID;
					byte_index_d = '0;
				end
			end
			PH_DATA: begin
				gather_d = gword;
				if (channels_q == CH_MONO) begin
					if (byte_index_q == 2'd1) begin
						frame_req    = 1'b1;
						frame_l      = gword[31:16];
						frame_r      = gword[31:16];
						byte_index_d = '0;
					end else begin
						byte_index_d = 2'd1;
					end
				end else begin
					if (byte_index_q == 2'd1) held_left_d = gword[31:16];
					if (byte_index_q == 2'd3) begin
						frame_req = 1'b1;
						frame_l   = held_left_q;
						frame_r   = gword[31:16];
					end
					byte_index_d = byte_index_q + 2'd1;
				end
				// frame limit closes the file with a good summary
				if (frame_req) begin
					count_d = count_q + FC_W'(1);
					if (count_d >= target_q) begin
						sum_req    = 1'b1;
						sum_status = ST_OK;
					end
				end
			end
			PH_DONE: ;
			default: ;
		endcase

		if (sum_req) phase_d = PH_DONE;

		// end of file without a summary yet
		if (last_s1 && phase_d != PH_DONE) begin
			sum_req = 1'b1;
			if (phase_d == PH_DATA) sum_status = (count_d != '0) ? ST_OK : ST_NO_FRAMES;
			else sum_status = ST_TRUNC;
		end

		// result records
		frame_res               = '0;
		frame_res.kind          = KIND_FRAME;
		frame_res.left_sample   = frame_l;
		frame_res.right_sample  = frame_r;
		frame_res.last_result   = !sum_req;

		sum_res                 = '0;
		sum_res.kind            = KIND_SUMMARY;
		sum_res.status          = sum_status;
		sum_res.sample_rate     = rate_d;
		sum_res.channel_count   = (channels_d == CH_MONO || channels_d == CH_STEREO) ?
			channels_d[1:0] : 2'd0;
		sum_res.header_frames   = hdr_d;
		sum_res.frames_out      = count_d;
		sum_res.last_result     = 1'b1;

		// last byte returns the file state to reset
		if (last_s1) begin
			phase_d      = PH_RIFF;
			byte_index_d = '0;
			gather_d     = '0;
			skip_d       = '0;
			pad_d        = 1'b0;
			have_fmt_d   = 1'b0;
			format_d     = '0;
			channels_d   = '0;
			rate_d       = '0;
			bits_d       = '0;
			target_d     = '0;
			count_d      = '0;
			held_left_d  = '0;
			fmt_pos_d    = '0;
			chunk_d      = CK_OTHER;
			hdr_d        = '0;
		end
	end

	// results toward the queue
	always_comb begin
		push       = '0;
		push.r0    = frame_req ? frame_res : sum_res;
		push.r1    = sum_res;
		if (advance) push.count = {1'b0, frame_req} + {1'b0, sum_req};
	end

	// file state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_RIFF;
			byte_index_q <= '0;
			gather_q     <= '0;
			skip_q       <= '0;
			pad_q        <= 1'b0;
			have_fmt_q   <= 1'b0;
			format_q     <= '0;
			channels_q   <= '0;
			rate_q       <= '0;
			bits_q       <= '0;
			target_q     <= '0;
			count_q      <= '0;
			held_left_q  <= '0;
			fmt_pos_q    <= '0;
			chunk_q      <= CK_OTHER;
			hdr_q        <= '0;
		end else if (advance) begin
			phase_q      <= phase_d;
			byte_index_q <= byte_index_d;
			gather_q     <= gather_d;
			skip_q       <= skip_d;
			pad_q        <= pad_d;
			have_fmt_q   <= have_fmt_d;
			format_q     <= format_d;
			channels_q   <= channels_d;
			rate_q       <= rate_d;
			bits_q       <= bits_d;
			target_q     <= target_d;
			count_q      <= count_d;
			held_left_q  <= held_left_d;
			fmt_pos_q    <= fmt_pos_d;
			chunk_q      <= chunk_d;
			hdr_q        <= hdr_d;
		end
	end

`ifndef SYNTH
	// a last byte always closes the file and restarts the walk
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && last_s1) |=> (phase_q == PH_RIFF))
		else $error("file state not cleared after last byte");

	// a last byte of a file still open always yields the summary
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && last_s1 && phase_q != PH_DONE) |-> (push.count != 2'd0))
		else $error("last byte without summary");

	// a pair is a frame then the closing summary
	assert property (@(posedge clk) disable iff (!arst_n)
		(push.count == 2'd2) |-> (push.r0.kind == KIND_FRAME &&
		push.r1.kind == KIND_SUMMARY && push.r1.last_result && !push.r0.last_result))
		else $error("bad result pair");
`endif

endmodule

// ===== hw/rtl/wavp_outq.sv =====
// small result queue between the parser and the output channel
module wavp_outq
	import wavp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  res_push_t push,
	output logic      room,
	output logic      out_valid,
	input  logic      out_stall,
	output result_t   out_res
);

	result_t           ent_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              pop;
	logic [QCNT_W-1:0] after_pop;

	assign out_valid = (count_q != '0);
	assign out_res   = ent_q[rd_ptr_q];
	assign pop       = out_valid && !out_stall;
	assign after_pop = count_q - {{(QCNT_W-1){1'b0}}, pop};
	// room for a frame and a summary once this cycle's transfer leaves
	assign room      = (after_pop <= QCNT_W'(QDEPTH - 2));

	// entry writes
	always_ff @(posedge clk) begin
		if (push.count != 2'd0) ent_q[wr_ptr_q] <= push.r0;
		if (push.count == 2'd2) ent_q[wr_ptr_q + QPTR_W'(1)] <= push.r1;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_W'(push.count);
			if (pop) rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			count_q  <= after_pop + QCNT_W'(push.count);
		end
	end

`ifndef SYNTH
	// pushes never overrun the queue
	assert property (@(posedge clk) disable iff (!arst_n)
		(push.count != 2'd0) |-> ((after_pop + QCNT_W'(push.count)) <= QCNT_W'(QDEPTH)))
		else $error("result queue overflow");
`endif

endmodule

// ===== hw/rtl/wav_pcm16_stream_parser.sv =====
// top level of the wav pcm16 stream parser: configuration registers and channels
// Usage: a WAV file enters one byte per transfer on the input channel
// (in_valid, in_stall, byte_in, last_byte), last_byte marking its final byte.
// The output channel (out_valid, out_stall and the result fields) carries
// stereo sample frames (kind 0, mono duplicated to both sides) and, for each
// file, exactly one summary (kind 1) with status, rate, channels and counts.
// last_result flags the final result caused by one byte.
// Throughput: one byte per cycle while the queue has room; each accepted
// byte updates the parser state. A byte that yields a frame and the summary puts
// two results into a four-entry queue, which drains one result per cycle unless
// the receiver stalls. An accepted byte goes into the input register; its
// results then go into a queue entry and on to the output channel.
// When the receiver stalls, results wait in the queue; the input channel
// stalls once the queue cannot take two more results. Reset clears the file
// state, empties the queue, sets expected_rate to 0 and max_frames to its
// largest value. Write configuration only while idle; the block does not check.
module wav_pcm16_stream_parser
	import wavp_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [0:0]              cfg_index,
	input  logic [31:0]             cfg_data,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [7:0]              byte_in,
	input  logic                    last_byte,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic                    kind,
	output logic signed [15:0]      left_sample,
	output logic signed [15:0]      right_sample,
	output logic [3:0]              status,
	output logic [31:0]             sample_rate,
	output logic [1:0]              channel_count,
	output logic [HDR_W-1:0]        header_frames,
	output logic [FC_W-1:0]         frames_out,
	output logic                    last_result
);

	logic [31:0]     expected_rate_q;
	logic [FC_W-1:0] max_frames_q;
	logic            room;
	res_push_t       push;
	result_t         out_res;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_rate_q <= '0;
			max_frames_q    <= '1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_EXPECTED_RATE: expected_rate_q <= cfg_data;
				CFG_MAX_FRAMES:    max_frames_q    <= cfg_data[FC_W-1:0];
				default: ;
			endcase
		end
	end

	wavp_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.byte_in       (byte_in),
		.last_byte     (last_byte),
		.expected_rate (expected_rate_q),
		.max_frames    (max_frames_q),
		.room          (room),
		.push          (push)
	);

	wavp_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (out_res)
	);

	// result fields
	assign kind          = out_res.kind;
	assign left_sample   = out_res.left_sample;
	assign right_sample  = out_res.right_sample;
	assign status        = out_res.status;
	assign sample_rate   = out_res.sample_rate;
	assign channel_count = out_res.channel_count;
	assign header_frames = out_res.header_frames;
	assign frames_out    = out_res.frames_out;
	assign last_result   = out_res.last_result;

endmodule

// ===== test/wav_pcm16_stream_parser_tb.sv =====
// testbench of the wav pcm16 stream parser: byte-level stimulus, result prediction and checks
module wav_pcm16_stream_parser_tb
	import wavp_pkg::*;
;

	// where the parser stands inside the file
	typedef enum logic [3:0] {
		SCAN_RIFF,
		SCAN_RSIZE,
		SCAN_WAVE,
		SCAN_CHUNK_ID,
		SCAN_CHUNK_SIZE,
		SCAN_FMT,
		SCAN_SKIP,
		SCAN_DATA,
		SCAN_DONE
	} scan_phase_t;

	typedef enum logic [1:0] {
		CHUNK_OTHER,
		CHUNK_FMT,
		CHUNK_DATA
	} chunk_kind_t;

	// predicts the frames and summaries of each file and matches them against the block
	class wav_result_tracker;
		logic [31:0]      rate_req;
		logic [FC_W-1:0]  frame_cap;
		scan_phase_t      phase;
		chunk_kind_t      chunk;
		logic [1:0]       word_pos;
		logic [31:0]      word;
		logic [31:0]      skip_left;
		logic             pad_due;
		logic             fmt_seen;
		logic             done;
		logic [15:0]      fmt_code;
		logic [15:0]      chans;
		logic [15:0]      bits;
		logic [15:0]      left_hold;
		logic [31:0]      rate;
		logic [31:0]      data_len;
		logic [FC_W-1:0]  target;
		logic [FC_W-1:0]  emitted;
		logic [3:0]       fmt_off;
		logic [HDR_W-1:0] announced;
		result_t          expected_results[$];
		int               mismatches;

		function new();
			rate_req = '0;
			frame_cap = '1;
			mismatches = 0;
			clear_file();
		endfunction

		function void clear_file();
			phase = SCAN_RIFF;
			chunk = CHUNK_OTHER;
			word_pos = '0;
			word = '0;
			skip_left = '0;
			pad_due = 1'b0;
			fmt_seen = 1'b0;
			done = 1'b0;
			fmt_code = '0;
			chans = '0;
			bits = '0;
			left_hold = '0;
			rate = '0;
			data_len = '0;
			target = '0;
			emitted = '0;
			fmt_off = '0;
			announced = '0;
		endfunction

		function void set_register(logic [0:0] idx, logic [31:0] val);
			if (idx == CFG_EXPECTED_RATE)
				rate_req = val;
			else
				frame_cap = val[FC_W-1:0];
		endfunction

		function int pending();
			return expected_results.size();
		endfunction

		function void push_frame(logic [15:0] l, logic [15:0] r);
			result_t res;
			res = '0;
			res.kind = KIND_FRAME;
			res.left_sample = l;
			res.right_sample = r;
			expected_results.push_back(res);
		endfunction

		// the summary closes the file: later bytes are ignored until the last one
		function void push_summary(status_t st);
			result_t res;
			res = '0;
			res.kind = KIND_SUMMARY;
			res.status = st;
			res.sample_rate = rate;
			res.channel_count = (chans == CH_MONO || chans == CH_STEREO) ? chans[1:0] : 2'd0;
			res.header_frames = announced;
			res.frames_out = emitted;
			expected_results.push_back(res);
			done = 1'b1;
			phase = SCAN_DONE;
		endfunction

		function void enter_skip(logic [31:0] cnt, logic pad);
			skip_left = cnt;
			pad_due = pad;
			phase = (cnt == 0 && !pad) ? SCAN_CHUNK_ID : SCAN_SKIP;
		endfunction

		// header checks at the data chunk, in priority order
		function void open_data();
			logic [31:0] frames;
			if (!fmt_seen)
				push_summary(ST_TRUNC);
			else if (fmt_code != FMT_PCM)
				push_summary(ST_NOT_PCM);
			else if (chans != CH_MONO && chans != CH_STEREO)
				push_summary(ST_BAD_CH);
			else if (bits != BITS_16)
				push_summary(ST_NOT_16);
			else if (rate_req != 0 && rate != rate_req)
				push_summary(ST_BAD_RATE);
			else begin
				frames = (data_len >> 1) / chans;
				announced = frames[HDR_W-1:0];
				if (frames > frame_cap)
					frames = frame_cap;
				target = frames[FC_W-1:0];
				emitted = '0;
				word_pos = '0;
				if (target == 0)
					push_summary(ST_NO_FRAMES);
				else
					phase = SCAN_DATA;
			end
		endfunction

		// one accepted input transfer
		function void take_byte(logic [7:0] b, logic lst);
			int      first;
			logic    full;
			logic    framed;
			status_t st;
			result_t res;
			first = expected_results.size();
			full = 1'b0;
			framed = 1'b0;
			// tags and sizes build up little endian, four bytes at a time
			if (!done && phase <= SCAN_CHUNK_SIZE) begin
				word = {b, word[31:8]};
				full = (word_pos == 2'd3);
				word_pos = word_pos + 2'd1;
			end
			if (!done) begin
				case (phase)
				SCAN_RIFF: if (full) begin
					if (word != TAG_RIFF)
						push_summary(ST_BAD_TAG);
					else
						phase = SCAN_RSIZE;
				end
				SCAN_RSIZE: if (full) begin
					phase = SCAN_WAVE;
				end
				SCAN_WAVE: if (full) begin
					if (word != TAG_WAVE)
						push_summary(ST_BAD_TAG);
					else
						phase = SCAN_CHUNK_ID;
				end
				SCAN_CHUNK_ID: if (full) begin
					if (word == TAG_FMT)
						chunk = CHUNK_FMT;
					else if (word == TAG_DATA)
						chunk = CHUNK_DATA;
					else
						chunk = CHUNK_OTHER;
					phase = SCAN_CHUNK_SIZE;
				end
				SCAN_CHUNK_SIZE: if (full) begin
					if (chunk == CHUNK_FMT) begin
						if (word < FMT_MIN_SIZE)
							push_summary(ST_FMT_SHORT);
						else begin
							skip_left = word - FMT_MIN_SIZE;
							fmt_off = '0;
							phase = SCAN_FMT;
						end
					end else if (chunk == CHUNK_DATA) begin
						data_len = word;
						open_data();
					end else begin
						enter_skip(word, word[0]);
					end
				end
				// fmt body: extra bytes past 16 are skipped with no pad byte
				SCAN_FMT: begin
					word = {b, word[31:8]};
					case (fmt_off)
					FPOS_FORMAT:   fmt_code = word[31:16];
					FPOS_CHANNELS: chans = word[31:16];
					FPOS_RATE:     rate = word;
					FPOS_BITS:     bits = word[31:16];
					default: ;
					endcase
					if (fmt_off == FPOS_BITS) begin
						fmt_seen = 1'b1;
						word_pos = '0;
						enter_skip(skip_left, 1'b0);
					end else begin
						fmt_off = fmt_off + 4'd1;
					end
				end
				SCAN_SKIP: begin
					if (skip_left != 0)
						skip_left = skip_left - 32'd1;
					else
						pad_due = 1'b0;
					if (skip_left == 0 && !pad_due) begin
						phase = SCAN_CHUNK_ID;
						word_pos = '0;
					end
				end
				// samples: mono goes to both sides
				SCAN_DATA: begin
					word = {b, word[31:8]};
					if (chans == CH_MONO) begin
						if (word_pos == 2'd1) begin
							push_frame(word[31:16], word[31:16]);
							framed = 1'b1;
							word_pos = 2'd0;
						end else begin
							word_pos = 2'd1;
						end
					end else begin
						if (word_pos == 2'd1)
							left_hold = word[31:16];
						if (word_pos == 2'd3) begin
							push_frame(left_hold, word[31:16]);
							framed = 1'b1;
						end
						word_pos = word_pos + 2'd1;
					end
					if (framed) begin
						emitted = emitted + 1'b1;
						if (emitted >= target)
							push_summary(ST_OK);
					end
				end
				default: ;
				endcase
			end
			// end of file: summary if none yet, then a fresh file
			if (lst) begin
				if (!done) begin
					if (phase != SCAN_DATA)
						st = ST_TRUNC;
					else if (emitted != 0)
						st = ST_OK;
					else
						st = ST_NO_FRAMES;
					push_summary(st);
				end
				clear_file();
			end
			if (expected_results.size() > first) begin
				res = expected_results.pop_back();
				res.last_result = 1'b1;
				expected_results.push_back(res);
			end
		endfunction

		function void check_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
				mismatches++;
			end
		endfunction

		// one accepted output transfer against the oldest expectation
		function void match_result(result_t got);
			result_t want;
			if (expected_results.size() == 0) begin
				$error("unexpected result: kind %0d status %0d", got.kind, got.status);
				mismatches++;
				return;
			end
			want = expected_results.pop_front();
			check_field("kind", want.kind, got.kind);
			check_field("left_sample", want.left_sample, got.left_sample);
			check_field("right_sample", want.right_sample, got.right_sample);
			check_field("status", want.status, got.status);
			check_field("sample_rate", want.sample_rate, got.sample_rate);
			check_field("channel_count", want.channel_count, got.channel_count);
			check_field("header_frames", want.header_frames, got.header_frames);
			check_field("frames_out", want.frames_out, got.frames_out);
			check_field("last_result", want.last_result, got.last_result);
		endfunction
	endclass

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES = 200;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_BYTES = 200;
	localparam int PHASES = 5;
	// full-scale samples, little endian: -32768, 32767, -1, 0
	localparam logic [63:0] FULL_SCALE = 64'h0000_FFFF_7FFF_8000;

	// ways to break a file
	typedef enum int {
		FLAW_NOT_PCM,
		FLAW_CHANNELS,
		FLAW_BITS,
		FLAW_RATE,
		FLAW_NO_FMT,
		FLAW_EMPTY,
		FLAW_FMT_SHORT,
		FLAW_TAG,
		FLAW_CUT,
		FLAW_NOISE
	} flaw_t;

	typedef struct {
		logic [15:0] fmt_code;
		logic [15:0] chans;
		logic [31:0] rate;
		logic [15:0] bits;
		int          fmt_extra;
		int          junk_before;
		int          junk_after;
		bit          with_fmt;
		logic [31:0] data_size;
		int          data_len;
	} wav_shape_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [0:0]         cfg_index = CFG_EXPECTED_RATE;
	logic [31:0]        cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [7:0]         byte_in = '0;
	logic               last_byte = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic               kind;
	logic signed [15:0] left_sample;
	logic signed [15:0] right_sample;
	logic [3:0]         status;
	logic [31:0]        sample_rate;
	logic [1:0]         channel_count;
	logic [HDR_W-1:0]   header_frames;
	logic [FC_W-1:0]    frames_out;
	logic               last_result;
	result_t            seen;

	wav_result_tracker tracker;
	logic [7:0]        file_bytes[$];
	int                fmt_size_at;
	logic [31:0]       cur_rate = '0;
	logic [FC_W-1:0]   cur_cap = '1;
	bit                gaps_on = 1'b1;
	bit                hold_req = 1'b0;

	wav_pcm16_stream_parser i_dut (.*);

	assign seen = {kind, left_sample, right_sample, status, sample_rate, channel_count,
		header_frames, frames_out, last_result};

	always #1 clk = ~clk;

	// file building
	function automatic void put_le(logic [31:0] v, int nbytes);
		for (int i = 0; i < nbytes; i++)
			file_bytes.push_back(v[8*i +: 8]);
	endfunction

	function automatic void add_random(int nbytes);
		for (int i = 0; i < nbytes; i++)
			file_bytes.push_back(8'($urandom_range(255)));
	endfunction

	// unknown chunks, odd sizes carry a pad byte
	function automatic void add_junk(int count);
		logic [31:0] sz;
		for (int c = 0; c < count; c++) begin
			sz = $urandom_range(5);
			put_le($urandom(), 4);
			put_le(sz, 4);
			add_random(sz + sz[0]);
		end
	endfunction

	function automatic void build_wav(wav_shape_t s);
		file_bytes.delete();
		put_le(TAG_RIFF, 4);
		put_le($urandom(), 4);
		put_le(TAG_WAVE, 4);
		add_junk(s.junk_before);
		if (s.with_fmt) begin
			put_le(TAG_FMT, 4);
			fmt_size_at = file_bytes.size();
			put_le(32'd16 + s.fmt_extra, 4);
			put_le(s.fmt_code, 2);
			put_le(s.chans, 2);
			put_le(s.rate, 4);
			// byte rate and block align are not checked
			put_le($urandom(), 4);
			put_le($urandom(), 2);
			put_le(s.bits, 2);
			add_random(s.fmt_extra);
		end
		add_junk(s.junk_after);
		put_le(TAG_DATA, 4);
		put_le(s.data_size, 4);
		add_random(s.data_len);
	endfunction

	function automatic wav_shape_t clean_shape();
		wav_shape_t s;
		s.fmt_code = FMT_PCM;
		s.chans = ($urandom_range(1) != 0) ? CH_STEREO : CH_MONO;
		s.rate = (cur_rate != 0) ? cur_rate : $urandom();
		s.bits = BITS_16;
		s.fmt_extra = ($urandom_range(3) == 0) ? $urandom_range(5, 1) : 0;
		s.junk_before = ($urandom_range(3) == 0) ? $urandom_range(2, 1) : 0;
		s.junk_after = ($urandom_range(3) == 0) ? 1 : 0;
		s.with_fmt = 1'b1;
		s.data_len = $urandom_range(24);
		s.data_size = s.data_len;
		return s;
	endfunction

	function automatic void make_broken(flaw_t flaw);
		wav_shape_t s;
		int         cut;
		int         at;
		s = clean_shape();
		case (flaw)
		FLAW_NOT_PCM:
			s.fmt_code = ($urandom_range(1) != 0) ? 16'd0 : 16'($urandom_range(65535, 2));
		FLAW_CHANNELS:
			s.chans = ($urandom_range(1) != 0) ? 16'd0 : 16'($urandom_range(65535, 3));
		FLAW_BITS:
			s.bits = ($urandom_range(1) != 0) ? 16'd8 : 16'($urandom_range(65535, 17));
		FLAW_RATE:
			s.rate = cur_rate ^ (32'd1 << $urandom_range(31));
		FLAW_NO_FMT:
			s.with_fmt = 1'b0;
		FLAW_EMPTY:
			s.data_size = $urandom_range(3);
		default: ;
		endcase
		build_wav(s);
		case (flaw)
		FLAW_FMT_SHORT:
			file_bytes[fmt_size_at] = 8'($urandom_range(15));
		FLAW_TAG: begin
			at = ($urandom_range(1) != 0) ? $urandom_range(3) : $urandom_range(11, 8);
			file_bytes[at] = file_bytes[at] ^ (8'd1 << $urandom_range(7));
		end
		FLAW_CUT: begin
			cut = $urandom_range(file_bytes.size() - 1, 1);
			while (file_bytes.size() > cut)
				void'(file_bytes.pop_back());
		end
		FLAW_NOISE: begin
			file_bytes.delete();
			add_random($urandom_range(12, 1));
		end
		default: ;
		endcase
	endfunction

	// one input transfer, with an occasional gap ahead of it
	task automatic send_byte(logic [7:0] b, logic lst);
		if (gaps_on && $urandom_range(99) < 3) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		in_valid <= 1'b1;
		byte_in <= b;
		last_byte <= lst;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic send_file();
		for (int i = 0; i < file_bytes.size(); i++)
			send_byte(file_bytes[i], i == file_bytes.size() - 1);
	endtask

	// wait for every expected result, then let the pipeline go quiet
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_settings(logic [31:0] rate, logic [FC_W-1:0] cap);
		cfg_we <= 1'b1;
		cfg_index <= CFG_EXPECTED_RATE;
		cfg_data <= rate;
		@(posedge clk);
		tracker.set_register(CFG_EXPECTED_RATE, rate);
		cfg_index <= CFG_MAX_FRAMES;
		cfg_data <= 32'(cap);
		@(posedge clk);
		tracker.set_register(CFG_MAX_FRAMES, 32'(cap));
		cfg_we <= 1'b0;
	endtask

	task automatic directed_files();
		wav_shape_t s;
		// every kind of broken file once
		for (int f = 0; f <= FLAW_NOISE; f++) begin
			make_broken(flaw_t'(f));
			send_file();
		end
		// stereo with full-scale samples
		s = clean_shape();
		s.chans = CH_STEREO;
		s.data_len = 8;
		s.data_size = 8;
		build_wav(s);
		for (int i = 0; i < 8; i++)
			file_bytes[file_bytes.size() - 8 + i] = FULL_SCALE[8*i +: 8];
		send_file();
		// mono, payload past the announced frames is ignored;
		// the receiver holds off so the queue fills and the input stalls
		s.chans = CH_MONO;
		s.data_size = 6;
		s.data_len = 9;
		build_wav(s);
		hold_req = 1'b1;
		send_file();
		// end of file inside the data with half a frame left over
		s.data_size = 1000;
		s.data_len = 5;
		build_wav(s);
		send_file();
		// end of file before the first stereo frame completes
		s.chans = CH_STEREO;
		s.data_len = 3;
		build_wav(s);
		send_file();
		// a file of one byte
		file_bytes.delete();
		add_random(1);
		send_file();
	endtask

	// mostly clean files with random content, the rest broken
	task automatic random_files(int budget);
		int         sent;
		wav_shape_t s;
		sent = 0;
		while (sent < budget) begin
			if ($urandom_range(99) < 65) begin
				s = clean_shape();
				if ($urandom_range(4) == 0)
					s.data_size = $urandom();
				else if ($urandom_range(4) == 0)
					s.data_size = $urandom_range(24);
				build_wav(s);
			end else begin
				make_broken(flaw_t'($urandom_range(FLAW_NOISE)));
			end
			sent += file_bytes.size();
			send_file();
		end
	endtask

	// sample both channels at the edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				tracker.take_byte(byte_in, last_byte);
			if (out_valid && !out_stall)
				tracker.match_result(seen);
		end
	end

	// receiver: random stalls, and one long hold-off on request
	initial begin : receiver
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
				out_stall <= 1'b0;
			end else if (gaps_on && $urandom_range(99) < 3) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(4, 1)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// ends the run when no transfer happens for too long
	initial begin : watchdog
		int quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("wav_pcm16_stream_parser_tb NOT OK");
		$finish;
	end

	initial begin : stimulus
		tracker = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// registers at their reset values first
		directed_files();
		settle();
		for (int p = 0; p < PHASES; p++) begin
			case (p)
			0: begin
				cur_rate = 32'd44100;
				cur_cap = '1;
				// receiver holds off while files keep coming
				hold_req = 1'b1;
			end
			1: begin
				cur_rate = '0;
				cur_cap = 1;
			end
			2: begin
				cur_rate = '1;
				cur_cap = 3;
			end
			3: begin
				cur_rate = 32'd8000;
				cur_cap = 2;
			end
			default: begin
				cur_rate = '0;
				cur_cap = '1;
			end
			endcase
			// one stretch with no idling on either side
			gaps_on = (p != 1);
			write_settings(cur_rate, cur_cap);
			random_files(RANDOM_BYTES / PHASES);
			settle();
		end
		if (tracker.mismatches == 0 && tracker.pending() == 0)
			$display("wav_pcm16_stream_parser_tb OK");
		else
			$display("wav_pcm16_stream_parser_tb NOT OK");
		$finish;
	end

endmodule
